// ===== design/pci_isa_bridge_irq_router_macros.svh =====
// ----------------------------------------------------------------------------
// PCI-to-ISA bridge IRQ router assertion macros
// Property shorthands for the bridge controller, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef PCI_ISA_BRIDGE_IRQ_ROUTER_MACROS_SVH
`define PCI_ISA_BRIDGE_IRQ_ROUTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIBR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pibr_pkg.sv =====
// ----------------------------------------------------------------------------
// pibr_pkg
// Types, codes and constant tables shared by the bridge modules.
// ----------------------------------------------------------------------------
package pibr_pkg;

    localparam int ISA_IRQS   = 16;
    localparam int PIRQ_LINES = 4;

    localparam logic [15:0] ALLOWED_IRQS = 16'hdef8;
    localparam logic [7:0]  ROUTE_MASK   = 8'h8f;
    localparam logic [7:0]  ELCR1_MASK   = 8'hf8;
    localparam logic [7:0]  ELCR2_MASK   = 8'hde;
    localparam logic [7:0]  UNROUTED     = 8'h80;
    localparam logic [5:0]  ROUTE_ROW    = 6'h18;  // offsets 0x60..0x63

    localparam logic [15:0] PORT_APM_CMD  = 16'h00b2;
    localparam logic [15:0] PORT_APM_STS  = 16'h00b3;
    localparam logic [15:0] PORT_ELCR1    = 16'h04d0;
    localparam logic [15:0] PORT_ELCR2    = 16'h04d1;
    localparam logic [15:0] PORT_RST_CTRL = 16'h0cf9;

    localparam logic [0:0] CFG_CHIPSET = 1'd0;
    localparam logic [0:0] CFG_IOAPIC  = 1'd1;

    typedef enum logic [2:0] {
        OP_IO_RD  = 3'd0,
        OP_IO_WR  = 3'd1,
        OP_CFG_RD = 3'd2,
        OP_CFG_WR = 3'd3,
        OP_EVENT  = 3'd4
    } t_op;

    localparam logic [1:0] RST_NONE = 2'd0;
    localparam logic [1:0] RST_SOFT = 2'd1;
    localparam logic [1:0] RST_HARD = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IO,
        S_EVT,
        S_CRD,
        S_CRD_CAP,
        S_CWR,
        S_UNR,
        S_RT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic io;
        logic event_go;
        logic rd_req;
        logic rd_cap;
        logic wr_byte;
        logic next_byte;
        logic unroute;
        logic route;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic bytes_done;
        logic need_unroute;
        logic need_route;
    } t_status;

    // Reset contents of the configuration space outside the routing bytes.
    function automatic logic [7:0] f_default_byte(input logic [7:0] off, input logic chip);
        logic [7:0] v;
        case (off)
            8'h00: v = 8'h86;
            8'h01: v = 8'h80;
            8'h02: v = chip ? 8'h00 : 8'h2e;
            8'h03: v = chip ? 8'h70 : 8'h12;
            8'h04: v = 8'h07;
            8'h07: v = 8'h02;
            8'h08: v = chip ? 8'h00 : 8'h01;
            8'h0a: v = 8'h01;
            8'h0b: v = 8'h06;
            8'h0e: v = 8'h80;
            8'h4c: v = 8'h4d;
            8'h4e: v = 8'h03;
            8'h69: v = 8'h02;
            8'h70: v = 8'h80;
            8'h76: v = 8'h0c;
            8'h77: v = 8'h0c;
            8'h78: v = 8'h02;
            8'ha0: v = 8'h08;
            8'ha8: v = 8'h0f;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic f_irq_allowed(input logic [7:0] irq);
        return (irq[7:4] == 4'd0) && ALLOWED_IRQS[irq[3:0]];
    endfunction

endpackage

// ===== design/pibr_datapath.sv =====
// ----------------------------------------------------------------------------
// pibr_datapath
// Item registers, configuration space memory, routing state and result
// registers of the bridge.
// ----------------------------------------------------------------------------
module pibr_datapath
    import pibr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data,
    input  logic [15:0] i_addr,
    input  logic [2:0]  i_access_len,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_source_devfunc,
    input  logic [2:0]  i_int_line,
    input  logic        i_int_level,
    output logic        o_strobe,
    output logic [31:0] o_read_data,
    output logic [15:0] o_irq_levels,
    output logic [15:0] o_irq_claimed,
    output logic [7:0]  o_elcr_master,
    output logic [7:0]  o_elcr_slave,
    output logic        o_smi_request,
    output logic [1:0]  o_reset_request,
    output logic        o_ioapic_valid,
    output logic [4:0]  o_ioapic_pin,
    output logic        o_ioapic_level
);

    // Latched item.
    logic [15:0] r_addr;
    logic [2:0]  r_len;
    logic [31:0] r_data;
    logic [4:0]  r_dev;
    logic [1:0]  r_pirq;
    logic        r_level;
    logic [2:0]  r_idx;

    // Architectural state.
    logic [7:0]  r_mem [256];
    logic [255:0] r_valid;
    logic [7:0]  r_route [PIRQ_LINES];
    logic [31:0] r_dev_mask [ISA_IRQS];
    logic [3:0]  r_share [ISA_IRQS];
    logic [7:0]  r_elcr1, r_elcr2, r_apm_cmd, r_apm_sts;
    logic        r_hard_sel, r_chip, r_ioapic_en;

    // Read staging and per-item results.
    logic [7:0]  r_mem_q;
    logic        r_valid_q;
    logic [7:0]  r_off_q;
    logic [31:0] r_rd;
    logic        r_smi;
    logic [1:0]  r_rst;
    logic        r_iov;
    logic [1:0]  r_iopirq;
    logic        r_iolvl;
    logic        r_strobe;
    logic [31:0] r_o_rd;
    logic [15:0] r_o_levels, r_o_claimed;
    logic        r_o_smi, r_o_iov, r_o_iolvl;
    logic [1:0]  r_o_rst;
    logic [4:0]  r_o_pin;

    logic [7:0]  off;
    logic [7:0]  wbyte;
    logic [7:0]  vmask;
    logic [1:0]  rp;
    logic [7:0]  stored;
    logic        is_route, is_ro;
    logic        cfg_wr;
    logic [7:0]  cap_byte;
    logic [7:0]  evt_irq;
    logic [3:0]  unr_share;
    logic [15:0] levels, claimed;
    logic [2:0]  eff_len;

    always_comb begin
        off      = r_addr[7:0] + {6'd0, r_idx[1:0]};
        wbyte    = r_data[8 * r_idx[1:0] +: 8];
        vmask    = wbyte & ROUTE_MASK;
        rp       = off[1:0];
        stored   = r_route[rp];
        is_route = (off[7:2] == ROUTE_ROW);
        is_ro    = (off == 8'h04) || (off == 8'h06) || (off >= 8'h10 && off < 8'h34);
        // Only a config byte step writes the memory; the io step shares wr_byte.
        cfg_wr   = i_cmd.wr_byte && !i_cmd.io && !is_ro && !is_route;
        o_status.bytes_done   = (r_idx == r_len);
        o_status.need_route   = is_route && !is_ro && (vmask != stored) && !vmask[7]
                                && f_irq_allowed(vmask);
        o_status.need_unroute = is_route && (vmask != stored) && (stored[7:4] == 4'd0)
                                && (vmask[7] || f_irq_allowed(vmask));
        if (r_off_q[7:2] == ROUTE_ROW) begin
            cap_byte = r_route[r_off_q[1:0]];
        end else if (r_valid_q) begin
            cap_byte = r_mem_q;
        end else begin
            cap_byte = f_default_byte(r_off_q, r_chip);
        end
        evt_irq   = r_route[r_pirq];
        unr_share = r_share[stored[3:0]] & ~(4'b0001 << rp);
        for (int i = 0; i < ISA_IRQS; i++) begin
            levels[i]  = |r_dev_mask[i];
            claimed[i] = |r_share[i];
        end
        if (i_access_len > 3'd4) begin
            eff_len = 3'd4;
        end else begin
            eff_len = i_access_len;
        end
    end

    // Item registers: payload, no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr  <= i_addr;
            r_len   <= eff_len;
            r_data  <= i_write_data;
            r_dev   <= i_source_devfunc[7:3];
            r_pirq  <= i_source_devfunc[4:3] + i_int_line[1:0] + 2'd2;
            r_level <= i_int_level;
        end
    end

    // Configuration memory: one write or one read per cycle.
    always_ff @(posedge i_clk) begin
        if (cfg_wr) begin
            r_mem[off] <= wbyte;
        end
        if (i_cmd.rd_req) begin
            r_mem_q <= r_mem[off];
            r_off_q <= off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_valid_q   <= 1'b0;
            r_chip      <= 1'b1;
            r_ioapic_en <= 1'b1;
            for (int i = 0; i < PIRQ_LINES; i++) begin
                r_route[i] <= UNROUTED;
            end
            for (int i = 0; i < ISA_IRQS; i++) begin
                r_dev_mask[i] <= '0;
                r_share[i]    <= '0;
            end
            r_elcr1    <= '0;
            r_elcr2    <= '0;
            r_apm_cmd  <= '0;
            r_apm_sts  <= '0;
            r_hard_sel <= 1'b0;
            r_idx      <= '0;
            r_rd       <= '0;
            r_smi      <= 1'b0;
            r_rst      <= RST_NONE;
            r_iov      <= 1'b0;
            r_iopirq   <= '0;
            r_iolvl    <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CHIPSET: begin
                        r_chip      <= i_cfg_data[0];
                        // ID bytes fall back to the newly selected defaults.
                        r_valid[2]  <= 1'b0;
                        r_valid[3]  <= 1'b0;
                        r_valid[8]  <= 1'b0;
                    end
                    CFG_IOAPIC: r_ioapic_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_idx <= '0;
                r_rd  <= '0;
                r_smi <= 1'b0;
                r_rst <= RST_NONE;
                r_iov <= 1'b0;
                r_iopirq <= '0;
                r_iolvl  <= 1'b0;
            end
            if (i_cmd.next_byte) begin
                r_idx <= r_idx + 3'd1;
            end
            if (i_cmd.rd_req) begin
                r_valid_q <= r_valid[off];
            end
            if (i_cmd.rd_cap) begin
                r_rd[8 * r_idx[1:0] +: 8] <= cap_byte;
            end
            if (cfg_wr) begin
                r_valid[off] <= 1'b1;
            end
            if (i_cmd.unroute) begin
                r_share[stored[3:0]] <= unr_share;
                if (unr_share == 4'd0) begin
                    r_dev_mask[stored[3:0]][1] <= 1'b0;
                end
                r_route[rp] <= UNROUTED;
            end
            if (i_cmd.route) begin
                r_route[rp] <= vmask;
                r_share[vmask[3:0]] <= r_share[vmask[3:0]] | (4'b0001 << rp);
            end
            if (i_cmd.io && !i_cmd.wr_byte) begin
                case (r_addr)
                    PORT_APM_CMD:  r_rd <= {24'd0, r_apm_cmd};
                    PORT_APM_STS:  r_rd <= {24'd0, r_apm_sts};
                    PORT_ELCR1:    r_rd <= {24'd0, r_elcr1};
                    PORT_ELCR2:    r_rd <= {24'd0, r_elcr2};
                    PORT_RST_CTRL: r_rd <= {30'd0, r_hard_sel, 1'b0};
                    default:       r_rd <= '1;
                endcase
            end
            if (i_cmd.wr_byte && i_cmd.io) begin
                // An io write reports zero read data, left from the load.
                case (r_addr)
                    PORT_APM_CMD: begin
                        r_apm_cmd <= r_data[7:0];
                        r_smi     <= 1'b1;
                    end
                    PORT_APM_STS: r_apm_sts <= r_data[7:0];
                    PORT_ELCR1:   r_elcr1   <= r_data[7:0] & ELCR1_MASK;
                    PORT_ELCR2:   r_elcr2   <= r_data[7:0] & ELCR2_MASK;
                    PORT_RST_CTRL: begin
                        r_hard_sel <= r_data[1];
                        if (r_data[2]) begin
                            r_rst <= r_data[1] ? RST_HARD : RST_SOFT;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.event_go) begin
                if (r_ioapic_en) begin
                    r_iov    <= 1'b1;
                    r_iopirq <= r_pirq;
                    r_iolvl  <= r_level;
                end
                if (f_irq_allowed(evt_irq)) begin
                    r_dev_mask[evt_irq[3:0]][r_dev] <= r_level;
                end
            end
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_rd      <= r_rd;
            r_o_levels  <= levels;
            r_o_claimed <= claimed;
            r_o_smi     <= r_smi;
            r_o_rst     <= r_rst;
            r_o_iov     <= r_iov;
            r_o_pin     <= r_iov ? {3'b100, r_iopirq} : 5'd0;
            r_o_iolvl   <= r_iolvl;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_read_data     = r_o_rd;
    assign o_irq_levels    = r_o_levels;
    assign o_irq_claimed   = r_o_claimed;
    assign o_elcr_master   = r_elcr1;
    assign o_elcr_slave    = r_elcr2;
    assign o_smi_request   = r_o_smi;
    assign o_reset_request = r_o_rst;
    assign o_ioapic_valid  = r_o_iov;
    assign o_ioapic_pin    = r_o_pin;
    assign o_ioapic_level  = r_o_iolvl;

endmodule

// ===== design/pibr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pibr_ctrl
// Sequencer that walks each item through io, event or per-byte config steps; an unknown op goes straight to done.
// ----------------------------------------------------------------------------
`include "pci_isa_bridge_irq_router_macros.svh"

module pibr_ctrl
    import pibr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_op,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;
    logic   r_do_route, n_do_route;
    logic   r_io_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_do_route <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_do_route <= n_do_route;
        end
    end

    // The io write flag travels with the io step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_io_wr <= 1'b0;
        end else if (r_state == S_IDLE && i_start) begin
            r_io_wr <= (i_op == OP_IO_WR);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_do_route = r_do_route;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_op)
                        OP_IO_RD, OP_IO_WR: n_state = S_IO;
                        OP_CFG_RD:          n_state = S_CRD;
                        OP_CFG_WR:          n_state = S_CWR;
                        OP_EVENT:           n_state = S_EVT;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_IO: begin
                // The io step reads, or writes instead for a write op.
                o_cmd.io      = 1'b1;
                o_cmd.wr_byte = r_io_wr;
                n_state       = S_DONE;
            end
            S_EVT: begin
                o_cmd.event_go = 1'b1;
                n_state        = S_DONE;
            end
            S_CRD: begin
                if (i_status.bytes_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_req = 1'b1;
                    n_state      = S_CRD_CAP;
                end
            end
            S_CRD_CAP: begin
                o_cmd.rd_cap    = 1'b1;
                o_cmd.next_byte = 1'b1;
                n_state         = S_CRD;
            end
            S_CWR: begin
                if (i_status.bytes_done) begin
                    n_state = S_DONE;
                end else if (i_status.need_unroute) begin
                    n_do_route = i_status.need_route;
                    n_state    = S_UNR;
                end else if (i_status.need_route) begin
                    n_state = S_RT;
                end else begin
                    o_cmd.wr_byte   = 1'b1;
                    o_cmd.next_byte = 1'b1;
                end
            end
            S_UNR: begin
                o_cmd.unroute = 1'b1;
                if (r_do_route) begin
                    n_state = S_RT;
                end else begin
                    o_cmd.next_byte = 1'b1;
                    n_state         = S_CWR;
                end
            end
            S_RT: begin
                o_cmd.route     = 1'b1;
                o_cmd.next_byte = 1'b1;
                n_state         = S_CWR;
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    `PIBR_ASSERT_NEXT(a_done_to_idle, r_state == S_DONE, r_state == S_IDLE, "done not idle")
    `PIBR_ASSERT_NEXT(a_event_path, r_state == S_IDLE && i_start && i_op == OP_EVENT, r_state == S_EVT, "event missed")
    `PIBR_ASSERT_NEXT(a_route_resumes, r_state == S_RT, r_state == S_CWR, "route did not resume")
    `PIBR_ASSERT_NOW(a_route_origin, r_state == S_RT, $past(r_state) == S_CWR || $past(r_state) == S_UNR, "bad route entry")

endmodule

// ===== design/pci_isa_bridge_irq_router.sv =====
// ----------------------------------------------------------------------------
// pci_isa_bridge_irq_router
// PCI-to-ISA bridge with io ports, a 256-byte configuration space and a
// four-line PIRQ router that feeds ISA IRQ levels and IOAPIC forwarding.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Handshake                     | Payload
//  ----------+-----------+-------------------------------+----------------------
//  item      | in        | start high while busy is low  | op, addr, len, data,...
//  result    | out       | o_strobe, one cycle, no stall | read data, IRQ state,...
//  config    | in        | i_cfg_we, taken every edge    | i_cfg_index, i_cfg_data
//
// An io access or an interrupt event takes one step before the done state, and
// an unknown op goes straight to done; the result strobe is registered from the
// done state. A config read takes one registered memory read and one capture
// for each byte. A config write steps through its bytes, adding an unroute step
// for each routing byte that unroutes a PIRQ line and a route step for each
// that routes it. Reset is synchronous and active low; the configuration space
// reads its default contents through per-byte valid flags, so no clearing pass
// is needed. Results cannot be stalled; busy is low in the strobe cycle, so the
// next item may be started there.
// ----------------------------------------------------------------------------
module pci_isa_bridge_irq_router
    import pibr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_addr,
    input  logic [2:0]  i_access_len,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_source_devfunc,
    input  logic [2:0]  i_int_line,
    input  logic        i_int_level,
    output logic        o_strobe,
    output logic [31:0] o_read_data,
    output logic [15:0] o_irq_levels,
    output logic [15:0] o_irq_claimed,
    output logic [7:0]  o_elcr_master,
    output logic [7:0]  o_elcr_slave,
    output logic        o_smi_request,
    output logic [1:0]  o_reset_request,
    output logic        o_ioapic_valid,
    output logic [4:0]  o_ioapic_pin,
    output logic        o_ioapic_level
);

    // The controller issues every step, including the write of an io write, so
    // the datapath does no sequencing of its own.
    t_cmd    cmd;
    t_status status;

    pibr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    pibr_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_addr           (i_addr),
        .i_access_len     (i_access_len),
        .i_write_data     (i_write_data),
        .i_source_devfunc (i_source_devfunc),
        .i_int_line       (i_int_line),
        .i_int_level      (i_int_level),
        .o_strobe         (o_strobe),
        .o_read_data      (o_read_data),
        .o_irq_levels     (o_irq_levels),
        .o_irq_claimed    (o_irq_claimed),
        .o_elcr_master    (o_elcr_master),
        .o_elcr_slave     (o_elcr_slave),
        .o_smi_request    (o_smi_request),
        .o_reset_request  (o_reset_request),
        .o_ioapic_valid   (o_ioapic_valid),
        .o_ioapic_pin     (o_ioapic_pin),
        .o_ioapic_level   (o_ioapic_level)
    );

endmodule

// ===== tb/sv/pci_isa_bridge_irq_router_test.sv =====
// ----------------------------------------------------------------------------
// pci_isa_bridge_irq_router_test
// Self-checking bench for the PCI-to-ISA bridge and PIRQ router. It sends io,
// config and interrupt items through the start/busy handshake, predicts every
// result with its own model of the bridge and checks each strobed result.
// ----------------------------------------------------------------------------
module pci_isa_bridge_irq_router_test;
    import pibr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [2:0]  len;
        logic [31:0] wdata;
        logic [7:0]  devfunc;
        logic [2:0]  line;
        logic        level;
    } t_item;

    typedef struct packed {
        logic [31:0] rdata;
        logic [15:0] levels;
        logic [15:0] claimed;
        logic [7:0]  elcr_m;
        logic [7:0]  elcr_s;
        logic        smi;
        logic [1:0]  rst_req;
        logic        io_valid;
        logic [4:0]  io_pin;
        logic        io_level;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [0:0] i_cfg_data;
    t_item drive_item;

    logic        o_strobe;
    logic [31:0] o_read_data;
    logic [15:0] o_irq_levels;
    logic [15:0] o_irq_claimed;
    logic [7:0]  o_elcr_master;
    logic [7:0]  o_elcr_slave;
    logic        o_smi_request;
    logic [1:0]  o_reset_request;
    logic        o_ioapic_valid;
    logic [4:0]  o_ioapic_pin;
    logic        o_ioapic_level;

    pci_isa_bridge_irq_router i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (drive_item.op),
        .i_addr          (drive_item.addr),
        .i_access_len    (drive_item.len),
        .i_write_data    (drive_item.wdata),
        .i_source_devfunc(drive_item.devfunc),
        .i_int_line      (drive_item.line),
        .i_int_level     (drive_item.level),
        .o_strobe        (o_strobe),
        .o_read_data     (o_read_data),
        .o_irq_levels    (o_irq_levels),
        .o_irq_claimed   (o_irq_claimed),
        .o_elcr_master   (o_elcr_master),
        .o_elcr_slave    (o_elcr_slave),
        .o_smi_request   (o_smi_request),
        .o_reset_request (o_reset_request),
        .o_ioapic_valid  (o_ioapic_valid),
        .o_ioapic_pin    (o_ioapic_pin),
        .o_ioapic_level  (o_ioapic_level)
    );

    // Pending items for the driver and results still owed by the bridge.
    t_item   pending_items[$];
    t_result owed_results[$];
    int      mismatches;
    bit      no_idle;

    // Shadow state of the bridge.
    logic [7:0]  shadow_cfg[256];
    logic [31:0] dev_masks[ISA_IRQS];
    logic [3:0]  share_masks[ISA_IRQS];
    logic [7:0]  sh_elcr_m, sh_elcr_s, sh_apm_cmd, sh_apm_sts;
    logic        sh_hard_sel, sh_chip, sh_ioapic;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow model of the bridge.
    // ------------------------------------------------------------------------
    function automatic void load_chip_ids();
        shadow_cfg[8'h02] = sh_chip ? 8'h00 : 8'h2e;
        shadow_cfg[8'h03] = sh_chip ? 8'h70 : 8'h12;
        shadow_cfg[8'h08] = sh_chip ? 8'h00 : 8'h01;
    endfunction

    function automatic void reset_bridge();
        for (int i = 0; i < 256; i++) shadow_cfg[i] = 8'h00;
        shadow_cfg[8'h00] = 8'h86;  shadow_cfg[8'h01] = 8'h80;
        shadow_cfg[8'h04] = 8'h07;  shadow_cfg[8'h07] = 8'h02;
        shadow_cfg[8'h0a] = 8'h01;  shadow_cfg[8'h0b] = 8'h06;
        shadow_cfg[8'h0e] = 8'h80;  shadow_cfg[8'h4c] = 8'h4d;
        shadow_cfg[8'h4e] = 8'h03;  shadow_cfg[8'h69] = 8'h02;
        shadow_cfg[8'h70] = 8'h80;  shadow_cfg[8'h76] = 8'h0c;
        shadow_cfg[8'h77] = 8'h0c;  shadow_cfg[8'h78] = 8'h02;
        shadow_cfg[8'ha0] = 8'h08;  shadow_cfg[8'ha8] = 8'h0f;
        for (int p = 0; p < PIRQ_LINES; p++) shadow_cfg[8'h60 + p] = UNROUTED;
        for (int i = 0; i < ISA_IRQS; i++) begin
            dev_masks[i] = '0;
            share_masks[i] = '0;
        end
        sh_chip = 1'b1;
        sh_ioapic = 1'b1;
        load_chip_ids();
        sh_elcr_m = '0; sh_elcr_s = '0; sh_apm_cmd = '0; sh_apm_sts = '0;
        sh_hard_sel = 1'b0;
    endfunction

    function automatic bit irq_ok(input logic [7:0] irq);
        return irq < ISA_IRQS && ALLOWED_IRQS[irq[3:0]];
    endfunction

    function automatic void set_device_level(input int pirq, input int dev, input logic lvl);
        logic [7:0] irq;
        irq = shadow_cfg[8'h60 + pirq];
        if (!irq_ok(irq)) return;
        if (lvl) dev_masks[irq[3:0]][dev] = 1'b1;
        else dev_masks[irq[3:0]][dev] = 1'b0;
    endfunction

    function automatic void unroute_line(input int pirq);
        logic [7:0] irq;
        irq = shadow_cfg[8'h60 + pirq];
        if (irq < ISA_IRQS) begin
            share_masks[irq[3:0]][pirq] = 1'b0;
            // The last line leaving an IRQ drops device 1's contribution.
            if (share_masks[irq[3:0]] == 0) set_device_level(pirq, 1, 1'b0);
            shadow_cfg[8'h60 + pirq] = UNROUTED;
        end
    endfunction

    function automatic void route_line(input int pirq, input logic [7:0] irq);
        if (!irq_ok(irq)) return;
        if (shadow_cfg[8'h60 + pirq] < ISA_IRQS) unroute_line(pirq);
        shadow_cfg[8'h60 + pirq] = irq;
        share_masks[irq[3:0]][pirq] = 1'b1;
    endfunction

    function automatic void write_config_byte(input logic [7:0] off, input logic [7:0] v);
        logic [7:0] m;
        if (off == 8'h04 || off == 8'h06 || (off >= 8'h10 && off < 8'h34)) return;
        if (off >= 8'h60 && off < 8'h64) begin
            m = v & ROUTE_MASK;
            if (m != shadow_cfg[off]) begin
                if (m >= UNROUTED) unroute_line(off[1:0]);
                else route_line(off[1:0], m);
            end
            return;
        end
        shadow_cfg[off] = v;
    endfunction

    function automatic t_result predict_result(input t_item it);
        t_result r;
        int n;
        int pirq;
        logic [7:0] off;
        r = '0;
        n = (it.len > 4) ? 4 : it.len;
        case (it.op)
            OP_IO_RD: begin
                case (it.addr)
                    PORT_APM_CMD:  r.rdata = {24'h0, sh_apm_cmd};
                    PORT_APM_STS:  r.rdata = {24'h0, sh_apm_sts};
                    PORT_ELCR1:    r.rdata = {24'h0, sh_elcr_m};
                    PORT_ELCR2:    r.rdata = {24'h0, sh_elcr_s};
                    PORT_RST_CTRL: r.rdata = sh_hard_sel ? 32'h2 : 32'h0;
                    default:       r.rdata = '1;
                endcase
            end
            OP_IO_WR: begin
                case (it.addr)
                    PORT_APM_CMD: begin
                        sh_apm_cmd = it.wdata[7:0];
                        r.smi = 1'b1;
                    end
                    PORT_APM_STS: sh_apm_sts = it.wdata[7:0];
                    PORT_ELCR1:   sh_elcr_m = it.wdata[7:0] & ELCR1_MASK;
                    PORT_ELCR2:   sh_elcr_s = it.wdata[7:0] & ELCR2_MASK;
                    PORT_RST_CTRL: begin
                        sh_hard_sel = it.wdata[1];
                        if (it.wdata[2]) r.rst_req = sh_hard_sel ? RST_HARD : RST_SOFT;
                    end
                    default: ;
                endcase
            end
            OP_CFG_RD: begin
                for (int i = 0; i < n; i++) begin
                    off = it.addr[7:0] + i;
                    r.rdata[8*i +: 8] = shadow_cfg[off];
                end
            end
            OP_CFG_WR: begin
                for (int i = 0; i < n; i++) begin
                    off = it.addr[7:0] + i;
                    write_config_byte(off, it.wdata[8*i +: 8]);
                end
            end
            OP_EVENT: begin
                pirq = (it.devfunc[7:3] + it.line + 2) % 4;
                if (sh_ioapic) begin
                    r.io_valid = 1'b1;
                    r.io_pin = 5'd16 + pirq;
                    r.io_level = it.level;
                end
                set_device_level(pirq, it.devfunc[7:3], it.level);
            end
            default: ;
        endcase
        for (int i = 0; i < ISA_IRQS; i++) begin
            r.levels[i] = dev_masks[i] != 0;
            r.claimed[i] = share_masks[i] != 0;
        end
        r.elcr_m = sh_elcr_m;
        r.elcr_s = sh_elcr_s;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: launches the next pending item, or idles at random.
    // ------------------------------------------------------------------------
    task automatic offer_next_item();
        if (pending_items.size() > 0 && (no_idle || $urandom_range(0, 99) >= 28)) begin
            drive_item <= pending_items.pop_front();
            start <= 1'b1;
        end else begin
            start <= 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            // The item on the ports is taken at this edge.
            owed_results.push_back(predict_result(drive_item));
            offer_next_item();
        end else if (!start) begin
            offer_next_item();
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every strobed result is matched against the oldest prediction.
    // ------------------------------------------------------------------------
    function automatic void report(input string name, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
    endfunction

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_strobe) begin
            if (owed_results.size() == 0) begin
                report("unexpected result", '0, o_read_data);
            end else begin
                e = owed_results.pop_front();
                if (o_read_data !== e.rdata) report("read_data", e.rdata, o_read_data);
                if (o_irq_levels !== e.levels) report("irq_levels", e.levels, o_irq_levels);
                if (o_irq_claimed !== e.claimed)
                    report("irq_claimed", e.claimed, o_irq_claimed);
                if (o_elcr_master !== e.elcr_m)
                    report("elcr_master", e.elcr_m, o_elcr_master);
                if (o_elcr_slave !== e.elcr_s) report("elcr_slave", e.elcr_s, o_elcr_slave);
                if (o_smi_request !== e.smi) report("smi_request", e.smi, o_smi_request);
                if (o_reset_request !== e.rst_req)
                    report("reset_request", e.rst_req, o_reset_request);
                if (o_ioapic_valid !== e.io_valid)
                    report("ioapic_valid", e.io_valid, o_ioapic_valid);
                if (o_ioapic_pin !== e.io_pin) report("ioapic_pin", e.io_pin, o_ioapic_pin);
                if (o_ioapic_level !== e.io_level)
                    report("ioapic_level", e.io_level, o_ioapic_level);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    function automatic t_item make_item(input logic [2:0] op, input logic [15:0] addr,
                                        input logic [2:0] len, input logic [31:0] wdata);
        t_item it;
        it.op = op;
        it.addr = addr;
        it.len = len;
        it.wdata = wdata;
        it.devfunc = $urandom_range(0, 255);
        it.line = $urandom_range(1, 4);
        it.level = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic logic [7:0] pick_allowed_irq();
        logic [7:0] irq;
        do irq = $urandom_range(0, 15); while (!irq_ok(irq));
        return irq;
    endfunction

    // Biased toward routing writes and events, so that lines get shared,
    // rerouted and unrouted while devices drive them.
    function automatic t_item random_item();
        t_item it;
        int pick;
        logic [15:0] ports[5];
        logic [31:0] d;
        ports = '{PORT_APM_CMD, PORT_APM_STS, PORT_ELCR1, PORT_ELCR2, PORT_RST_CTRL};
        pick = $urandom_range(0, 99);
        it = make_item(OP_EVENT, $urandom, $urandom_range(0, 7), $urandom);
        if (pick < 32) begin
            // Few devices so that the same bits get set and cleared again.
            it.devfunc = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                   : {$urandom_range(0, 3), 3'($urandom)};
            if ($urandom_range(0, 9) == 0) it.line = $urandom_range(0, 7);
        end else if (pick < 57) begin
            d = $urandom;
            for (int i = 0; i < 4; i++) begin
                case ($urandom_range(0, 5))
                    0:       d[8*i +: 8] = UNROUTED | 8'($urandom_range(0, 15));
                    1:       d[8*i +: 8] = $urandom_range(0, 255);
                    default: d[8*i +: 8] = pick_allowed_irq();
                endcase
            end
            it.op = OP_CFG_WR;
            it.addr = {$urandom_range(0, 255), 8'h60 + 8'($urandom_range(0, 3))};
            it.len = $urandom_range(1, 4);
            it.wdata = d;
        end else if (pick < 72) begin
            it.op = $urandom_range(0, 1) ? OP_IO_WR : OP_IO_RD;
            if ($urandom_range(0, 5) != 0) it.addr = ports[$urandom_range(0, 4)];
        end else if (pick < 86) begin
            it.op = OP_CFG_RD;
        end else if (pick < 95) begin
            it.op = OP_CFG_WR;
        end else begin
            it.op = $urandom_range(5, 7);
        end
        return it;
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || start || owed_results.size() != 0);
    endtask

    task automatic write_setting(input logic [0:0] idx, input logic [0:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CHIPSET) begin
            sh_chip = val;
            load_chip_ids();
        end else begin
            sh_ioapic = val;
        end
    endtask

    initial begin
        logic [1:0] settings[5];
        settings = '{2'b00, 2'b10, 2'b01, 2'b11, 2'b00};
        mismatches = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        drive_item = '0;
        reset_bridge();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items: every port, access-length edges, offset wrap,
        // read-only bytes, sharing, disallowed IRQs, odd lines, unknown ops.
        pending_items.push_back(make_item(OP_IO_RD, PORT_APM_CMD, 3'd1, '0));
        pending_items.push_back(make_item(OP_IO_WR, PORT_APM_CMD, 3'd1, 32'hffff_ffff));
        pending_items.push_back(make_item(OP_IO_WR, PORT_APM_STS, 3'd1, 32'h0000_00ff));
        pending_items.push_back(make_item(OP_IO_WR, PORT_ELCR1, 3'd1, 32'hffff_ffff));
        pending_items.push_back(make_item(OP_IO_WR, PORT_ELCR2, 3'd1, 32'hffff_ffff));
        pending_items.push_back(make_item(OP_IO_WR, PORT_RST_CTRL, 3'd1, 32'h0000_0006));
        pending_items.push_back(make_item(OP_IO_RD, PORT_RST_CTRL, 3'd1, '0));
        pending_items.push_back(make_item(OP_IO_WR, PORT_RST_CTRL, 3'd1, 32'h0000_0004));
        pending_items.push_back(make_item(OP_IO_RD, 16'hffff, 3'd7, '0));
        pending_items.push_back(make_item(OP_CFG_RD, 16'h0000, 3'd0, '0));
        pending_items.push_back(make_item(OP_CFG_RD, 16'hfffe, 3'd4, '0));
        pending_items.push_back(make_item(OP_CFG_RD, 16'h0000, 3'd7, '0));
        pending_items.push_back(make_item(OP_CFG_WR, 16'h0010, 3'd4, 32'hffff_ffff));
        pending_items.push_back(make_item(OP_CFG_WR, 16'h0003, 3'd4, 32'hffff_ffff));
        pending_items.push_back(make_item(OP_CFG_RD, 16'h0003, 3'd4, '0));
        pending_items.push_back(make_item(OP_CFG_WR, 16'h0060, 3'd4, 32'h0b0a_0905));
        pending_items.push_back(make_item(OP_CFG_WR, 16'h0061, 3'd1, 32'h0000_0001));
        pending_items.push_back(make_item(OP_CFG_WR, 16'h0062, 3'd1, 32'h0000_0005));
        begin
            t_item ev;
            ev = make_item(OP_EVENT, '0, 3'd1, '0);
            ev.devfunc = 8'h08; ev.line = 3'd0; ev.level = 1'b1;
            pending_items.push_back(ev);
            ev.line = 3'd7;
            pending_items.push_back(ev);
            ev.devfunc = 8'hff; ev.line = 3'd4;
            pending_items.push_back(ev);
        end
        pending_items.push_back(make_item(OP_CFG_WR, 16'h0060, 3'd1, 32'h0000_0080));
        pending_items.push_back(make_item(OP_CFG_RD, 16'h0060, 3'd4, '0));
        pending_items.push_back(make_item(3'd7, 16'h04d0, 3'd1, 32'h0000_0000));
        wait_idle();

        // Random phases under several register settings; one runs with no
        // idling at all on the driver side.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_setting(CFG_CHIPSET, settings[ph - 1][1]);
                write_setting(CFG_IOAPIC, settings[ph - 1][0]);
            end
            no_idle = (ph == 3);
            for (int k = 0; k < 175; k++) pending_items.push_back(random_item());
            wait_idle();
        end

        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
